// ----- rtl/core/owik_pkg.sv -----
// Shared types and constants for the omni wheel inverse kinematics pipeline.
// No dependencies; every other file refers to this package by scoped names.
package owik_pkg;

  localparam int VEL_W   = 16;  // Q8.8 velocity fields
  localparam int CFG_W   = 16;  // widest configuration register
  localparam int LIM_W   = 15;  // speed limit register
  localparam int PRD_W   = 33;  // velocity times constant / distance
  localparam int A_W     = 41;  // per-wheel sum, 24 fraction bits
  localparam int P_W     = 57;  // sum times inverse radius, 32 fraction bits
  localparam int FRAC_SH = 24;
  localparam int MAG_W   = 32;  // raw wheel speed magnitude
  localparam int NUM_W   = MAG_W + LIM_W;
  localparam int Q_W     = LIM_W;            // scaled quotient never exceeds the limit
  localparam int D_W     = MAG_W + Q_W - 1;  // divisor aligned to the top quotient bit
  localparam int NWHEEL  = 4;
  localparam int IDX_W   = 2;

  localparam logic [15:0] SIN45_Q16 = 16'd46341;

  // Wheel i takes -x when NEG_X[i], -y when NEG_Y[i]
  localparam logic [NWHEEL-1:0] NEG_X = 4'b0011;
  localparam logic [NWHEEL-1:0] NEG_Y = 4'b0110;

  localparam logic [IDX_W-1:0] REG_INV_RADIUS = 2'd0;
  localparam logic [IDX_W-1:0] REG_WHEEL_DIST = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED  = 2'd2;

  localparam logic [CFG_W-1:0] RST_INV_RADIUS = 16'd5120;
  localparam logic [CFG_W-1:0] RST_WHEEL_DIST = 16'd51;
  localparam logic [LIM_W-1:0] RST_MAX_SPEED  = 15'd2560;

  typedef struct packed {
    logic signed [VEL_W-1:0] x_velocity;
    logic signed [VEL_W-1:0] y_velocity;
    logic signed [VEL_W-1:0] angular_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] speed_wheel_one;
    logic signed [VEL_W-1:0] speed_wheel_two;
    logic signed [VEL_W-1:0] speed_wheel_three;
    logic signed [VEL_W-1:0] speed_wheel_four;
    logic                    was_scaled;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] inv_wheel_radius;
    logic [CFG_W-1:0] wheel_distance;
    logic [LIM_W-1:0] max_wheel_speed;
  } cfg_t;

  typedef struct packed {
    logic                         valid;
    logic [NWHEEL-1:0]            neg;
    logic [NWHEEL-1:0][MAG_W-1:0] mag;
  } kin_t;

  typedef struct packed {
    logic                         valid;
    logic                         scaled;
    logic [NWHEEL-1:0]            neg;
    logic [NWHEEL-1:0][VEL_W-1:0] raw;
    logic [NWHEEL-1:0][NUM_W-1:0] rem;
    logic [NWHEEL-1:0][Q_W-1:0]   quo;
    logic [D_W-1:0]               div;
  } div_t;

endpackage

// ----- rtl/core/omni_wheel_inverse_kinematics_unit.sv -----
// Top level of the omni wheel inverse kinematics unit: configuration
// registers, kinematics front end, desaturation divider chain, output register.
// Depends on owik_pkg, owik_kin, owik_limit and owik_div_step.
//
//   channel | ports                      | direction | payload
//   in      | in_valid, in_stall, in_item | input     | in_item_t
//   out     | out_valid, out_stall, out_item | output | out_item_t
//   cfg     | cfg_we, cfg_index, cfg_data | input     | 16-bit register write
//
// One transaction accepted per cycle unless a held result is stalled. Stages:
// four kinematics stages, two limit stages, fifteen divider steps, the output
// register. The 15-step restoring divider sets the depth.
// Synchronous active-low reset clears valid bits and restores register defaults.
// A stalled output freezes the whole pipeline; in_stall follows out_stall only
// while a result is held.
module omni_wheel_inverse_kinematics_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  owik_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output owik_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic [owik_pkg::IDX_W-1:0] cfg_index,
  input  logic [owik_pkg::CFG_W-1:0] cfg_data
);

  owik_pkg::cfg_t      cfg_r;
  owik_pkg::kin_t      kin;
  owik_pkg::div_t      stage [owik_pkg::Q_W+1];
  owik_pkg::out_item_t out_item_r, out_item_nxt;
  logic                out_valid_r;
  logic                en;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_wheel_radius <= owik_pkg::RST_INV_RADIUS;
      cfg_r.wheel_distance   <= owik_pkg::RST_WHEEL_DIST;
      cfg_r.max_wheel_speed  <= owik_pkg::RST_MAX_SPEED;
    end else if (cfg_we) begin
      case (cfg_index)
        owik_pkg::REG_INV_RADIUS: cfg_r.inv_wheel_radius <= cfg_data;
        owik_pkg::REG_WHEEL_DIST: cfg_r.wheel_distance   <= cfg_data;
        owik_pkg::REG_MAX_SPEED:  cfg_r.max_wheel_speed  <= cfg_data[owik_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  owik_kin u_kin (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .kin_o    (kin)
  );

  owik_limit u_limit (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .kin_i           (kin),
    .max_wheel_speed (cfg_r.max_wheel_speed),
    .div_o           (stage[0])
  );

  for (genvar g = 0; g < owik_pkg::Q_W; g++) begin : g_div
    owik_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (stage[g]),
      .d_o   (stage[g+1])
    );
  end

  always_comb begin
    logic [owik_pkg::NWHEEL-1:0][owik_pkg::VEL_W-1:0] spd;
    logic [owik_pkg::VEL_W-1:0] q;
    for (int i = 0; i < owik_pkg::NWHEEL; i++) begin
      q = owik_pkg::VEL_W'(stage[owik_pkg::Q_W].quo[i]);
      if (stage[owik_pkg::Q_W].scaled) begin
        spd[i] = stage[owik_pkg::Q_W].neg[i] ? -q : q;
      end else begin
        spd[i] = stage[owik_pkg::Q_W].raw[i];
      end
    end
    out_item_nxt.speed_wheel_one   = spd[0];
    out_item_nxt.speed_wheel_two   = spd[1];
    out_item_nxt.speed_wheel_three = spd[2];
    out_item_nxt.speed_wheel_four  = spd[3];
    out_item_nxt.was_scaled        = stage[owik_pkg::Q_W].scaled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stage[owik_pkg::Q_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // an empty output register never pushes back on the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with empty output register");

  // a held result freezes the last divider step
  a_div_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(stage[owik_pkg::Q_W]))
    else $error("divider advanced during output stall");

  // scaling only happens with a nonzero largest magnitude
  a_scaled_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (stage[0].valid && stage[0].scaled) |-> (stage[0].div != '0))
    else $error("scaling seeded with zero divisor");

endmodule

// ----- rtl/core/owik_kin.sv -----
// Kinematics front end: velocity products, wheel sums, inverse radius scaling
// and magnitude extraction over four register stages. Uses owik_pkg.
module owik_kin (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  owik_pkg::in_item_t in_item,
  input  owik_pkg::cfg_t   cfg,
  output owik_pkg::kin_t   kin_o
);

  logic signed [owik_pkg::PRD_W-1:0] tx_r, ty_r, tw_r;
  logic signed [owik_pkg::PRD_W-1:0] tx_nxt, ty_nxt, tw_nxt;
  logic signed [owik_pkg::A_W-1:0]   a_r   [owik_pkg::NWHEEL];
  logic signed [owik_pkg::A_W-1:0]   a_nxt [owik_pkg::NWHEEL];
  logic signed [owik_pkg::P_W-1:0]   p_r   [owik_pkg::NWHEEL];
  logic signed [owik_pkg::P_W-1:0]   p_nxt [owik_pkg::NWHEEL];
  logic [owik_pkg::NWHEEL-1:0]       neg_r, neg_nxt;
  logic [owik_pkg::NWHEEL-1:0][owik_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic v1_r, v2_r, v3_r, v4_r;

  always_comb begin
    tx_nxt = in_item.x_velocity * $signed({1'b0, owik_pkg::SIN45_Q16});
    ty_nxt = in_item.y_velocity * $signed({1'b0, owik_pkg::SIN45_Q16});
    tw_nxt = $signed({1'b0, cfg.wheel_distance}) * in_item.angular_velocity;
  end

  always_comb begin
    logic signed [owik_pkg::A_W-1:0] ax, ay, aw;
    ax = owik_pkg::A_W'(tx_r);
    ay = owik_pkg::A_W'(ty_r);
    // distance term has 16 fraction bits, align to 24
    aw = owik_pkg::A_W'(tw_r) <<< 8;
    for (int i = 0; i < owik_pkg::NWHEEL; i++) begin
      a_nxt[i] = (owik_pkg::NEG_X[i] ? -ax : ax) + (owik_pkg::NEG_Y[i] ? -ay : ay) + aw;
    end
  end

  always_comb begin
    logic signed [owik_pkg::A_W+owik_pkg::CFG_W:0] prod;
    for (int i = 0; i < owik_pkg::NWHEEL; i++) begin
      prod     = a_r[i] * $signed({1'b0, cfg.inv_wheel_radius});
      p_nxt[i] = prod[owik_pkg::P_W-1:0];
    end
  end

  always_comb begin
    logic [owik_pkg::P_W-1:0] pabs;
    for (int i = 0; i < owik_pkg::NWHEEL; i++) begin
      neg_nxt[i] = p_r[i][owik_pkg::P_W-1];
      pabs       = neg_nxt[i] ? owik_pkg::P_W'(-p_r[i]) : owik_pkg::P_W'(p_r[i]);
      // truncation toward zero: shift the magnitude
      mag_nxt[i] = pabs[owik_pkg::FRAC_SH +: owik_pkg::MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r  <= tx_nxt;
      ty_r  <= ty_nxt;
      tw_r  <= tw_nxt;
      a_r   <= a_nxt;
      p_r   <= p_nxt;
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign kin_o.valid = v4_r;
  assign kin_o.neg   = neg_r;
  assign kin_o.mag   = mag_r;

endmodule

// ----- rtl/core/owik_limit.sv -----
// Desaturation set-up: scaled numerators, largest magnitude, limit compare and
// divider seeding over two register stages. Uses owik_pkg.
module owik_limit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  owik_pkg::kin_t             kin_i,
  input  logic [owik_pkg::LIM_W-1:0] max_wheel_speed,
  output owik_pkg::div_t             div_o
);

  logic                   v5_r, v6_r;
  logic [owik_pkg::NWHEEL-1:0] neg5_r, neg6_r;
  logic [owik_pkg::NWHEEL-1:0][owik_pkg::VEL_W-1:0] raw5_r, raw6_r, raw_nxt;
  logic [owik_pkg::NWHEEL-1:0][owik_pkg::NUM_W-1:0] num5_r, num6_r, num_nxt;
  logic [owik_pkg::MAG_W-1:0] m01_r, m23_r, m01_nxt, m23_nxt, m_nxt, m6_r;
  logic                       scaled_nxt, scaled6_r;

  always_comb begin
    for (int i = 0; i < owik_pkg::NWHEEL; i++) begin
      num_nxt[i] = owik_pkg::NUM_W'(kin_i.mag[i]) * owik_pkg::NUM_W'(max_wheel_speed);
      raw_nxt[i] = kin_i.neg[i] ? -kin_i.mag[i][owik_pkg::VEL_W-1:0]
                                :  kin_i.mag[i][owik_pkg::VEL_W-1:0];
    end
    m01_nxt = (kin_i.mag[0] > kin_i.mag[1]) ? kin_i.mag[0] : kin_i.mag[1];
    m23_nxt = (kin_i.mag[2] > kin_i.mag[3]) ? kin_i.mag[2] : kin_i.mag[3];
    m_nxt      = (m01_r > m23_r) ? m01_r : m23_r;
    scaled_nxt = m_nxt > owik_pkg::MAG_W'(max_wheel_speed);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v5_r <= kin_i.valid;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg5_r    <= kin_i.neg;
      raw5_r    <= raw_nxt;
      num5_r    <= num_nxt;
      m01_r     <= m01_nxt;
      m23_r     <= m23_nxt;
      neg6_r    <= neg5_r;
      raw6_r    <= raw5_r;
      num6_r    <= num5_r;
      m6_r      <= m_nxt;
      scaled6_r <= scaled_nxt;
    end
  end

  always_comb begin
    div_o.valid  = v6_r;
    div_o.scaled = scaled6_r;
    div_o.neg    = neg6_r;
    div_o.raw    = raw6_r;
    div_o.rem    = num6_r;
    div_o.quo    = '0;
    div_o.div    = {m6_r, (owik_pkg::Q_W-1)'(0)};
  end

endmodule

// ----- rtl/core/owik_div_step.sv -----
// One registered restoring-division step, four wheels side by side; the
// aligned divisor moves one bit right per step. Uses owik_pkg.
module owik_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  owik_pkg::div_t d_i,
  output owik_pkg::div_t d_o
);

  owik_pkg::div_t d_r, d_nxt;

  always_comb begin
    logic [owik_pkg::NUM_W-1:0] dv;
    d_nxt = d_i;
    dv    = owik_pkg::NUM_W'(d_i.div);
    for (int i = 0; i < owik_pkg::NWHEEL; i++) begin
      if (d_i.rem[i] >= dv) begin
        d_nxt.rem[i] = d_i.rem[i] - dv;
        d_nxt.quo[i] = {d_i.quo[i][owik_pkg::Q_W-2:0], 1'b1};
      end else begin
        d_nxt.quo[i] = {d_i.quo[i][owik_pkg::Q_W-2:0], 1'b0};
      end
    end
    d_nxt.div = d_i.div >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_i.valid;
    end
    if (en) begin
      d_r.scaled <= d_nxt.scaled;
      d_r.neg    <= d_nxt.neg;
      d_r.raw    <= d_nxt.raw;
      d_r.rem    <= d_nxt.rem;
      d_r.quo    <= d_nxt.quo;
      d_r.div    <= d_nxt.div;
    end
  end

  assign d_o = d_r;

endmodule
